// File: rtl/core/s2cd_pkg.sv
// ============================================================================
// s2cd_pkg: shared types and constants for the seconds-to-date converter
// Datapath operation codes, status struct, reciprocal constants, month table.
// ============================================================================
package s2cd_pkg;

    // Datapath operation codes issued by the controller
    typedef logic [3:0] dp_op_t;

    localparam dp_op_t OP_HOLD      = 4'd0;
    localparam dp_op_t OP_LOAD      = 4'd1;
    localparam dp_op_t OP_MUL60     = 4'd2;
    localparam dp_op_t OP_MUL24     = 4'd3;
    localparam dp_op_t OP_SPLIT_SEC = 4'd4;
    localparam dp_op_t OP_SPLIT_MIN = 4'd5;
    localparam dp_op_t OP_SPLIT_HR  = 4'd6;
    localparam dp_op_t OP_YEAR      = 4'd7;
    localparam dp_op_t OP_MONTH     = 4'd8;
    localparam dp_op_t OP_OUT       = 4'd9;

    // Status back to the controller
    typedef struct packed {
        logic year_done;
        logic month_done;
    } dp_status_t;

    // Widths
    localparam int TIME_W  = 32;
    localparam int PROD_W  = 64;
    localparam int DAYS_W  = 16;   // at most 49710 days in 32 bits of seconds
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;

    // Exact reciprocals: floor(x / 60) = (x * RECIP_60) >> 37,
    // floor(x / 24) = (x * RECIP_24) >> 36, for every 32-bit x.
    localparam logic [TIME_W-1:0] RECIP_60 = 32'h8888_8889;
    localparam logic [TIME_W-1:0] RECIP_24 = 32'hAAAA_AAAB;
    localparam int                Q60_LSB  = 37;
    localparam int                Q24_LSB  = 36;

    // Calendar constants
    localparam logic [YEAR_W-1:0]  EPOCH_YEAR  = 12'd2000;
    localparam logic [8:0]         DAYS_LEAP   = 9'd366;
    localparam logic [8:0]         DAYS_COMMON = 9'd365;
    localparam logic [6:0]         CENTURY_LAST = 7'd99;
    localparam logic [8:0]         QUAD_CENT_LAST = 9'd399;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_LAST  = 4'd11;

    // Days in month (0 = January)
    function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] mon,
                                              input logic leap);
        logic [4:0] len;
        begin
            unique case (mon)
                4'd0:    len = 5'd31;
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd2:    len = 5'd31;
                4'd3:    len = 5'd30;
                4'd4:    len = 5'd31;
                4'd5:    len = 5'd30;
                4'd6:    len = 5'd31;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd30;
                4'd9:    len = 5'd31;
                4'd10:   len = 5'd30;
                4'd11:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// File: rtl/core/s2cd_dp.sv
// ============================================================================
// s2cd_dp: datapath of the seconds-to-date converter
// Shared reciprocal multiplier, remainder split, year and month stepping,
// and the output register.
// ============================================================================
module s2cd_dp
    import s2cd_pkg::*;
(
    input  logic                 clk,
    input  dp_op_t               cmd,
    input  logic [TIME_W-1:0]    elapsed_seconds,
    output dp_status_t           status,
    output logic [YEAR_W-1:0]    year,
    output logic [MONTH_W-1:0]   month,
    output logic [DAY_W-1:0]     day_of_month,
    output logic [HOUR_W-1:0]    hour,
    output logic [MIN_W-1:0]     minute,
    output logic [SEC_W-1:0]     second
);

    logic [TIME_W-1:0]  work_reg,  work_next;
    logic [PROD_W-1:0]  prod_reg,  prod_next;
    logic [SEC_W-1:0]   sec_reg,   sec_next;
    logic [MIN_W-1:0]   min_reg,   min_next;
    logic [HOUR_W-1:0]  hr_reg,    hr_next;
    logic [DAYS_W-1:0]  days_reg,  days_next;
    logic [YEAR_W-1:0]  yr_reg,    yr_next;
    logic               leap_reg,  leap_next;
    logic [6:0]         mod100_reg, mod100_next;
    logic [8:0]         mod400_reg, mod400_next;
    logic [MONTH_W-1:0] mon_reg,   mon_next;

    logic [YEAR_W-1:0]  year_o_reg,  year_o_next;
    logic [MONTH_W-1:0] month_o_reg, month_o_next;
    logic [DAY_W-1:0]   day_o_reg,   day_o_next;
    logic [HOUR_W-1:0]  hour_o_reg,  hour_o_next;
    logic [MIN_W-1:0]   min_o_reg,   min_o_next;
    logic [SEC_W-1:0]   sec_o_reg,   sec_o_next;

    logic [TIME_W-1:0]  mult_const;
    logic [TIME_W-1:0]  q60, q60x60, rem60;
    logic [TIME_W-1:0]  q24, q24x24, rem24;
    logic [DAYS_W-1:0]  year_len;
    logic [DAYS_W-1:0]  mon_len;
    logic [YEAR_W-1:0]  yr_inc;
    logic [6:0]         mod100_inc;
    logic [8:0]         mod400_inc;

    always_comb
    begin
        mult_const = (cmd == OP_MUL24) ? RECIP_24 : RECIP_60;

        // quotient from the registered product, remainder by shifts, adds and subtracts
        q60    = TIME_W'(prod_reg[PROD_W-1:Q60_LSB]);
        q60x60 = (q60 << 6) - (q60 << 2);
        rem60  = work_reg - q60x60;
        q24    = TIME_W'(prod_reg[PROD_W-1:Q24_LSB]);
        q24x24 = (q24 << 4) + (q24 << 3);
        rem24  = work_reg - q24x24;

        year_len = DAYS_W'(leap_reg ? DAYS_LEAP : DAYS_COMMON);
        mon_len  = DAYS_W'(month_days(mon_reg, leap_reg));

        // next year and its leap flag via mod-100 / mod-400 counters
        yr_inc     = yr_reg + 1'b1;
        mod100_inc = (mod100_reg == CENTURY_LAST) ? 7'd0 : mod100_reg + 1'b1;
        mod400_inc = (mod400_reg == QUAD_CENT_LAST) ? 9'd0 : mod400_reg + 1'b1;
    end

    assign status.year_done  = (days_reg < year_len);
    assign status.month_done = (mon_reg == MONTH_LAST) || (days_reg < mon_len);

    always_comb
    begin
        work_next    = work_reg;
        prod_next    = prod_reg;
        sec_next     = sec_reg;
        min_next     = min_reg;
        hr_next      = hr_reg;
        days_next    = days_reg;
        yr_next      = yr_reg;
        leap_next    = leap_reg;
        mod100_next  = mod100_reg;
        mod400_next  = mod400_reg;
        mon_next     = mon_reg;
        year_o_next  = year_o_reg;
        month_o_next = month_o_reg;
        day_o_next   = day_o_reg;
        hour_o_next  = hour_o_reg;
        min_o_next   = min_o_reg;
        sec_o_next   = sec_o_reg;

        unique case (cmd)
            OP_LOAD:
            begin
                work_next   = elapsed_seconds;
                yr_next     = EPOCH_YEAR;
                leap_next   = 1'b1;
                mod100_next = 7'd0;
                mod400_next = 9'd0;
                mon_next    = '0;
            end
            OP_MUL60, OP_MUL24:
            begin
                prod_next = PROD_W'(work_reg) * PROD_W'(mult_const);
            end
            OP_SPLIT_SEC:
            begin
                work_next = q60;
                sec_next  = rem60[SEC_W-1:0];
            end
            OP_SPLIT_MIN:
            begin
                work_next = q60;
                min_next  = rem60[MIN_W-1:0];
            end
            OP_SPLIT_HR:
            begin
                days_next = q24[DAYS_W-1:0];
                hr_next   = rem24[HOUR_W-1:0];
            end
            OP_YEAR:
            begin
                days_next   = days_reg - year_len;
                yr_next     = yr_inc;
                mod100_next = mod100_inc;
                mod400_next = mod400_inc;
                leap_next   = (mod400_inc == 9'd0) ||
                              ((yr_inc[1:0] == 2'd0) && (mod100_inc != 7'd0));
            end
            OP_MONTH:
            begin
                days_next = days_reg - mon_len;
                mon_next  = mon_reg + 1'b1;
            end
            OP_OUT:
            begin
                year_o_next  = yr_reg;
                month_o_next = mon_reg + 1'b1;
                day_o_next   = days_reg[DAY_W-1:0] + 1'b1;
                hour_o_next  = hr_reg;
                min_o_next   = min_reg;
                sec_o_next   = sec_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        prod_reg    <= prod_next;
        sec_reg     <= sec_next;
        min_reg     <= min_next;
        hr_reg      <= hr_next;
        days_reg    <= days_next;
        yr_reg      <= yr_next;
        leap_reg    <= leap_next;
        mod100_reg  <= mod100_next;
        mod400_reg  <= mod400_next;
        mon_reg     <= mon_next;
        year_o_reg  <= year_o_next;
        month_o_reg <= month_o_next;
        day_o_reg   <= day_o_next;
        hour_o_reg  <= hour_o_next;
        min_o_reg   <= min_o_next;
        sec_o_reg   <= sec_o_next;
    end

    assign year         = year_o_reg;
    assign month        = month_o_reg;
    assign day_of_month = day_o_reg;
    assign hour         = hour_o_reg;
    assign minute       = min_o_reg;
    assign second       = sec_o_reg;

endmodule

// File: rtl/core/s2cd_ctrl.sv
// ============================================================================
// s2cd_ctrl: sequencer of the seconds-to-date converter
// Walks the datapath through division, year and month steps; owns the
// input stall and output valid.
// ============================================================================
module s2cd_ctrl
    import s2cd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_op_t     cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL1  = 4'd1;
    localparam logic [3:0] ST_SPL1  = 4'd2;
    localparam logic [3:0] ST_MUL2  = 4'd3;
    localparam logic [3:0] ST_SPL2  = 4'd4;
    localparam logic [3:0] ST_MUL3  = 4'd5;
    localparam logic [3:0] ST_SPL3  = 4'd6;
    localparam logic [3:0] ST_YEAR  = 4'd7;
    localparam logic [3:0] ST_MONTH = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = OP_HOLD;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = OP_LOAD;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd        = OP_MUL60;
                state_next = ST_SPL1;
            end
            ST_SPL1:
            begin
                cmd        = OP_SPLIT_SEC;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd        = OP_MUL60;
                state_next = ST_SPL2;
            end
            ST_SPL2:
            begin
                cmd        = OP_SPLIT_MIN;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd        = OP_MUL24;
                state_next = ST_SPL3;
            end
            ST_SPL3:
            begin
                cmd        = OP_SPLIT_HR;
                state_next = ST_YEAR;
            end
            ST_YEAR:
            begin
                if (status.year_done)
                    state_next = ST_MONTH;
                else
                    cmd = OP_YEAR;
            end
            ST_MONTH:
            begin
                if (!status.month_done)
                    cmd = OP_MONTH;
                else if (!out_valid_reg || !out_stall)
                begin
                    cmd        = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a fresh result wins over the slot being emptied
    always_comb
    begin
        priority if (cmd == OP_OUT)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/seconds_to_calendar_date_unit.sv
// ============================================================================
// seconds_to_calendar_date_unit: seconds since 2000-01-01 to Gregorian date
// Top level; joins the sequencer and the datapath.
// ============================================================================
// One transaction carries a 32-bit count of seconds since 2000-01-01 00:00:00
// and returns one transaction with year, month, day, hour, minute and second.
// Every input value is legal (the top of the range lands in 2136). The block
// works on one transaction at a time: after acceptance it loads the input,
// divides it by 60, 60 and 24, steps over the whole years past 2000 (0..136)
// and then over the months (index 0..11), and loads the output register.
// The two walks together are longest in December 2135, since the top of the
// input range falls in February 2136. The year walk dominates: one year is
// subtracted per cycle, followed by one month per cycle. Seconds, minutes
// and hours come from one shared 32x32 reciprocal multiplier; each division
// is a multiply step followed by a split step.
// The output register holds a finished result while the next transaction
// is accepted and processed; a second result waits in the working registers,
// with the sequencer in its month state, until the output register is taken.
// ============================================================================
module seconds_to_calendar_date_unit
    import s2cd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [TIME_W-1:0]   elapsed_seconds,
    // output channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [YEAR_W-1:0]   year,
    output logic [MONTH_W-1:0]  month,
    output logic [DAY_W-1:0]    day_of_month,
    output logic [HOUR_W-1:0]   hour,
    output logic [MIN_W-1:0]    minute,
    output logic [SEC_W-1:0]    second
);

    dp_op_t     dp_cmd;
    dp_status_t dp_status;

    // sequencer: division steps, year walk, month walk, output load
    s2cd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // datapath: multiplier, remainders, calendar counters, output register
    s2cd_dp u_dp
    (
        .clk             (clk),
        .cmd             (dp_cmd),
        .elapsed_seconds (elapsed_seconds),
        .status          (dp_status),
        .year            (year),
        .month           (month),
        .day_of_month    (day_of_month),
        .hour            (hour),
        .minute          (minute),
        .second          (second)
    );

`ifndef SYNTH
    // an accepted transaction blocks the input until its work is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after acceptance");

    // time-of-day fields in range whenever a result is offered
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59))
        else $error("time of day out of range");

    // date fields in range whenever a result is offered
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month >= 4'd1) && (month <= 4'd12) &&
                      (day_of_month >= 5'd1) &&
                      (year >= 12'd2000) && (year <= 12'd2136))
        else $error("calendar date out of range");
`endif

endmodule
